FILE: sv/ffsts_pkg.sv
// Package for the fractional fixed-step tick scheduler: widths, register indexes,
// micro-op and branch codes, the control word type and the microprogram ROM.
// Has no dependencies.
package ffsts_pkg;

    localparam int TIME_W  = 64;
    localparam int STEP_W  = 30;
    localparam int CATCH_W = 4;
    localparam int PC_W    = 5;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 160;
    localparam int M_TUSER_W = 2;
    localparam int CFG_IDX_W = 2;

    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [STEP_W-1:0]  t_step;
    typedef logic [CATCH_W-1:0] t_catch;
    typedef logic [PC_W-1:0]    t_pc;

    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_REM  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CATCH = 2'd3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_POLL  = 1'b1;

    typedef logic [3:0] t_uop;
    localparam t_uop UOP_NOP     = 4'd0;
    localparam t_uop UOP_WAIT_IN = 4'd1;
    localparam t_uop UOP_CMP     = 4'd2;
    localparam t_uop UOP_TICK    = 4'd3;
    localparam t_uop UOP_SUM     = 4'd4;
    localparam t_uop UOP_STEP    = 4'd5;
    localparam t_uop UOP_DL_ADD  = 4'd6;
    localparam t_uop UOP_DL_NOW  = 4'd7;
    localparam t_uop UOP_EMIT_T  = 4'd8;
    localparam t_uop UOP_EMIT_D  = 4'd9;
    localparam t_uop UOP_CLR     = 4'd10;

    typedef logic [2:0] t_cond;
    localparam t_cond COND_NEVER    = 3'd0;
    localparam t_cond COND_ALWAYS   = 3'd1;
    localparam t_cond COND_OP_START = 3'd2;
    localparam t_cond COND_DUE      = 3'd3;
    localparam t_cond COND_NOT_DUE  = 3'd4;
    localparam t_cond COND_LIMIT    = 3'd5;

    typedef struct packed {
        t_uop  uop;
        t_cond cond;
        t_pc   target;
        logic  clr_count;
    } t_ctrl;

    localparam t_pc PC_IDLE   = 5'd0;
    localparam t_pc PC_LOOP   = 5'd3;
    localparam t_pc PC_DROP   = 5'd11;
    localparam t_pc PC_START  = 5'd15;

    function automatic t_ctrl ucode_rom(input t_pc addr);
        t_ctrl w;
        w = '{uop: UOP_NOP, cond: COND_ALWAYS, target: PC_IDLE, clr_count: 1'b0};
        unique case (addr)
            5'd0:  w = '{UOP_WAIT_IN, COND_OP_START, PC_START, 1'b0};
            5'd1:  w = '{UOP_CMP,     COND_NEVER,    PC_IDLE,  1'b1};
            5'd2:  w = '{UOP_NOP,     COND_NOT_DUE,  PC_IDLE,  1'b0};
            5'd3:  w = '{UOP_NOP,     COND_LIMIT,    PC_DROP,  1'b0};
            5'd4:  w = '{UOP_TICK,    COND_NEVER,    PC_IDLE,  1'b0};
            5'd5:  w = '{UOP_SUM,     COND_NEVER,    PC_IDLE,  1'b0};
            5'd6:  w = '{UOP_STEP,    COND_NEVER,    PC_IDLE,  1'b0};
            5'd7:  w = '{UOP_DL_ADD,  COND_NEVER,    PC_IDLE,  1'b0};
            5'd8:  w = '{UOP_CMP,     COND_NEVER,    PC_IDLE,  1'b0};
            5'd9:  w = '{UOP_EMIT_T,  COND_DUE,      PC_LOOP,  1'b0};
            5'd10: w = '{UOP_NOP,     COND_ALWAYS,   PC_IDLE,  1'b0};
            5'd11: w = '{UOP_SUM,     COND_NEVER,    PC_IDLE,  1'b0};
            5'd12: w = '{UOP_STEP,    COND_NEVER,    PC_IDLE,  1'b0};
            5'd13: w = '{UOP_DL_NOW,  COND_NEVER,    PC_IDLE,  1'b0};
            5'd14: w = '{UOP_EMIT_D,  COND_ALWAYS,   PC_IDLE,  1'b0};
            5'd15: w = '{UOP_CLR,     COND_NEVER,    PC_IDLE,  1'b0};
            5'd16: w = '{UOP_SUM,     COND_NEVER,    PC_IDLE,  1'b0};
            5'd17: w = '{UOP_STEP,    COND_NEVER,    PC_IDLE,  1'b0};
            5'd18: w = '{UOP_DL_NOW,  COND_ALWAYS,   PC_IDLE,  1'b0};
            default: w = '{UOP_NOP,   COND_ALWAYS,   PC_IDLE,  1'b0};
        endcase
        return w;
    endfunction

endpackage

FILE: sv/fractional_fixed_step_tick_scheduler.sv
// Fixed-rate tick scheduler with bounded catch-up, run by a microprogrammed sequencer.
// Depends on ffsts_pkg for the microprogram ROM, codes and types.
//
// Usage: the slave stream takes one beat per command, with tuser selecting start or
// poll and tdata carrying the current time in nanoseconds. A start beat anchors the
// schedule and gives no output. A poll beat gives one master beat per due tick, up
// to the catch-up limit, then one drop beat if a backlog remains; tlast marks the
// final beat of the poll. A poll with nothing due gives no output.
// Timing: one micro-instruction executes per cycle unless the input or output stalls.
// A start clears the schedule, accumulates, steps and sets the deadline. Each tick of
// a poll counts it, accumulates, steps, advances the deadline, compares and emits;
// a drop accumulates, steps, re-anchors the deadline and emits. A shared step unit
// accumulates, then compares and subtracts; the deadline update and compare are 64-bit.
// The output is a single register, so the sequencer runs ahead while the receiver
// holds a beat and stalls only when it must load the next one. Configuration
// writes are always accepted and are meant to happen while no command is active.
// Reset is synchronous and active low; it restores the default registers and
// clears the schedule, so a poll before any start uses a zero step.
module fractional_fixed_step_tick_scheduler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // now_ns [63:0]
    input  logic [ffsts_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // operation [0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tick_number [63:0], server_time_ns [127:64], step_ns [157:128], zero [159:158]
    output logic [ffsts_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // is_tick [0], backlog_dropped [1]
    output logic [ffsts_pkg::M_TUSER_W-1:0]    m_axis_tuser,
    output logic                               m_axis_tlast,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ffsts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ffsts_pkg::STEP_W-1:0]       i_cfg_data
);
    import ffsts_pkg::*;

    t_step  r_rate, r_base, r_rem;
    t_catch r_max_catch;

    t_step  r_acc, r_pending, r_res_step;
    t_time  r_deadline, r_count, r_time, r_now;
    logic [STEP_W:0] r_sum;
    logic   r_due;
    t_catch r_n;
    t_pc    r_pc, n_pc;

    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic [M_TUSER_W-1:0] r_out_user;
    logic                 r_out_last;

    t_ctrl ctrl;
    logic  in_acc, out_free, stall, cond_true;
    logic  sum_ge;
    logic [STEP_W:0] sum_sub;
    t_step step_inc, new_step, new_acc;

    assign ctrl          = ucode_rom(r_pc);
    assign s_axis_tready = (ctrl.uop == UOP_WAIT_IN);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

    always_comb begin
        sum_ge   = r_sum >= {1'b0, r_rate};
        sum_sub  = r_sum - {1'b0, r_rate};
        step_inc = (r_base == {STEP_W{1'b1}}) ? r_base : r_base + t_step'(1);
        new_step = sum_ge ? step_inc : r_base;
        new_acc  = sum_ge ? sum_sub[STEP_W-1:0] : r_sum[STEP_W-1:0];
    end

    always_comb begin
        stall = 1'b0;
        if (ctrl.uop == UOP_WAIT_IN && !in_acc) begin
            stall = 1'b1;
        end else if ((ctrl.uop == UOP_EMIT_T || ctrl.uop == UOP_EMIT_D) && !out_free) begin
            stall = 1'b1;
        end
    end

    always_comb begin
        unique case (ctrl.cond)
            COND_NEVER:    cond_true = 1'b0;
            COND_ALWAYS:   cond_true = 1'b1;
            COND_OP_START: cond_true = (s_axis_tuser == OP_START);
            COND_DUE:      cond_true = r_due;
            COND_NOT_DUE:  cond_true = !r_due;
            COND_LIMIT:    cond_true = (r_n >= r_max_catch);
            default:       cond_true = 1'b0;
        endcase
    end

    always_comb begin
        if (stall) begin
            n_pc = r_pc;
        end else if (cond_true) begin
            n_pc = ctrl.target;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= STEP_W'(128);
            r_base      <= STEP_W'(7812500);
            r_rem       <= '0;
            r_max_catch <= CATCH_W'(5);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_TICK_RATE: r_rate      <= i_cfg_data;
                REG_STEP_BASE: r_base      <= i_cfg_data;
                REG_STEP_REM:  r_rem       <= i_cfg_data;
                REG_MAX_CATCH: r_max_catch <= i_cfg_data[CATCH_W-1:0];
                default:       r_rate      <= r_rate;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= PC_IDLE;
            r_acc      <= '0;
            r_pending  <= '0;
            r_deadline <= '0;
            r_count    <= '0;
            r_time     <= '0;
            r_n        <= '0;
            r_due      <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (!stall) begin
                unique case (ctrl.uop)
                    UOP_CMP: begin
                        r_due <= r_now >= r_deadline;
                        if (ctrl.clr_count) begin
                            r_n <= '0;
                        end
                    end
                    UOP_TICK: begin
                        r_count <= r_count + t_time'(1);
                        r_time  <= r_time + TIME_W'(r_pending);
                        r_n     <= r_n + t_catch'(1);
                    end
                    UOP_STEP: begin
                        r_acc     <= new_acc;
                        r_pending <= new_step;
                    end
                    UOP_DL_ADD: r_deadline <= r_deadline + TIME_W'(r_pending);
                    UOP_DL_NOW: r_deadline <= r_now + TIME_W'(r_pending);
                    UOP_CLR: begin
                        r_count <= '0;
                        r_time  <= '0;
                        r_acc   <= '0;
                    end
                    UOP_NOP, UOP_WAIT_IN, UOP_SUM, UOP_EMIT_T, UOP_EMIT_D: begin
                        r_due <= r_due;
                    end
                    default: r_due <= r_due;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_now <= s_axis_tdata;
        end
        if (!stall && ctrl.uop == UOP_SUM) begin
            r_sum <= {1'b0, r_acc} + {1'b0, r_rem};
        end
        if (!stall && ctrl.uop == UOP_TICK) begin
            r_res_step <= r_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!stall && (ctrl.uop == UOP_EMIT_T || ctrl.uop == UOP_EMIT_D)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall && ctrl.uop == UOP_EMIT_T) begin
            r_out_data <= {2'b00, r_res_step, r_time, r_count};
            r_out_user <= 2'b01;
            r_out_last <= !r_due;
        end else if (!stall && ctrl.uop == UOP_EMIT_D) begin
            r_out_data <= {2'b00, r_pending, r_time, r_count};
            r_out_user <= 2'b10;
            r_out_last <= 1'b1;
        end
    end

endmodule

FILE: dv/tb_fractional_fixed_step_tick_scheduler.sv
// Testbench for the fractional fixed-step tick scheduler: a tick-schedule predictor in a
// scoreboard class checks every master beat against directed and random command streams.
// Depends on ffsts_pkg and the fractional_fixed_step_tick_scheduler RTL.
`timescale 1ns / 100ps

module tb_fractional_fixed_step_tick_scheduler;
    import ffsts_pkg::*;

    localparam int HOLD_OFF   = 40;
    localparam int MAX_REPORT = 100;

    typedef struct {
        logic  is_tick;
        t_time tick_number;
        t_time server_ns;
        t_step step;
        logic  dropped;
        logic  last;
    } t_tick_report;

    class tick_scoreboard;
        t_step        rate_hz;
        t_step        base_ns;
        t_step        rem_ns;
        t_catch       catch_limit;
        t_step        acc;
        t_time        deadline;
        t_step        pending_step;
        t_time        tick_count;
        t_time        elapsed_ns;
        t_tick_report reports[$];
        int           error_count;

        function new();
            rate_hz      = 30'd128;
            base_ns      = 30'd7812500;
            rem_ns       = '0;
            catch_limit  = 4'd5;
            acc          = '0;
            deadline     = '0;
            pending_step = '0;
            tick_count   = '0;
            elapsed_ns   = '0;
            error_count  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, t_step val);
            case (idx)
                REG_TICK_RATE: rate_hz = val;
                REG_STEP_BASE: base_ns = val;
                REG_STEP_REM:  rem_ns = val;
                REG_MAX_CATCH: catch_limit = val[CATCH_W-1:0];
                default: ;
            endcase
        endfunction

        function t_step consume_step();
            logic [31:0] sum;
            t_step       step;
            step = base_ns;
            sum  = {2'b00, acc} + {2'b00, rem_ns};
            if (sum >= {2'b00, rate_hz}) begin
                sum  = sum - {2'b00, rate_hz};
                step = (base_ns == '1) ? base_ns : base_ns + 1'b1;
            end
            acc = sum[STEP_W-1:0];
            return step;
        endfunction

        function void push_report(logic is_tick);
            t_tick_report r;
            r.is_tick     = is_tick;
            r.tick_number = tick_count;
            r.server_ns   = elapsed_ns;
            r.step        = pending_step;
            r.dropped     = !is_tick;
            r.last        = 1'b0;
            reports.push_back(r);
        endfunction

        function void note_command(logic op, t_time now);
            int n;
            n = 0;
            if (op == OP_START) begin
                tick_count   = '0;
                elapsed_ns   = '0;
                acc          = '0;
                pending_step = consume_step();
                deadline     = now + 64'(pending_step);
                return;
            end
            while (now >= deadline && n < int'(catch_limit)) begin
                tick_count = tick_count + 1;
                elapsed_ns = elapsed_ns + 64'(pending_step);
                push_report(1'b1);
                n++;
                pending_step = consume_step();
                deadline     = deadline + 64'(pending_step);
            end
            if (now >= deadline) begin
                pending_step = consume_step();
                deadline     = now + 64'(pending_step);
                push_report(1'b0);
                n++;
            end
            if (n > 0)
                reports[reports.size()-1].last = 1'b1;
        endfunction

        function void mismatch(string field, t_time exp_val, t_time act_val);
            // Past a hundred mismatches the count still grows but the log stays short.
            if (error_count < MAX_REPORT)
                $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_val, act_val);
            error_count++;
        endfunction

        function void check_beat(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user,
                                 logic last);
            t_tick_report r;
            if (reports.size() == 0) begin
                if (error_count < MAX_REPORT)
                    $error("unexpected beat: tdata 0x%0h tuser %b tlast %b", data, user, last);
                error_count++;
                return;
            end
            r = reports.pop_front();
            if (user[0] !== r.is_tick)
                mismatch("is_tick", 64'(r.is_tick), 64'(user[0]));
            if (data[63:0] !== r.tick_number)
                mismatch("tick_number", r.tick_number, data[63:0]);
            if (data[127:64] !== r.server_ns)
                mismatch("server_time_ns", r.server_ns, data[127:64]);
            if (data[157:128] !== r.step)
                mismatch("step_ns", 64'(r.step), 64'(data[157:128]));
            if (user[1] !== r.dropped)
                mismatch("backlog_dropped", 64'(r.dropped), 64'(user[1]));
            if (last !== r.last)
                mismatch("last", 64'(r.last), 64'(last));
        endfunction

        function int pending_count();
            return reports.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [M_TUSER_W-1:0]   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [STEP_W-1:0]      i_cfg_data;

    tick_scoreboard sb = new();
    int             src_idle_pct;
    int             sink_stall_pct;
    t_time          clock_ns;

    fractional_fixed_step_tick_scheduler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input t_step val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_cmd(input logic op, input t_time now);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= now;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(op, now);
    endtask

    // Hold the command stream until every predicted beat has arrived, then let a
    // start or an empty poll still inside the sequencer run out.
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge i_clk);
        repeat (HOLD_OFF) @(posedge i_clk);
    endtask

    task automatic run_phase(input int n_items, input int src_pct, input int sink_pct,
                             input t_step rate, input t_step base, input t_step rem,
                             input t_step catch_word);
        int    pick;
        int    k;
        t_time now;
        settle();
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        cfg_write(REG_TICK_RATE, rate);
        cfg_write(REG_STEP_BASE, base);
        cfg_write(REG_STEP_REM, rem);
        cfg_write(REG_MAX_CATCH, catch_word);
        clock_ns = {$urandom, $urandom};
        send_cmd(OP_START, clock_ns);
        repeat (n_items) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_cmd(OP_START, clock_ns);
            end else if (pick < 16) begin
                now = {$urandom, $urandom};
                send_cmd(logic'($urandom_range(1)), now);
                if (pick < 12)
                    clock_ns = now;
            end else begin
                k = $urandom_range(0, int'(catch_word[CATCH_W-1:0]) + 3);
                clock_ns = clock_ns + 64'(base) * 64'(k) + 64'($urandom_range(0, int'(base)));
                send_cmd(OP_POLL, clock_ns);
            end
            if ($urandom_range(49) == 0)
                settle();
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = OP_START;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = REG_TICK_RATE;
        i_cfg_data     = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        clock_ns       = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Poll before any start, then the default schedule through catch-up and a drop.
        send_cmd(OP_POLL, 64'd0);
        send_cmd(OP_POLL, 64'd0);
        send_cmd(OP_START, 64'd0);
        send_cmd(OP_POLL, 64'd23437500);
        send_cmd(OP_POLL, 64'd156250000);
        // Deadlines that wrap past the top of the time range.
        send_cmd(OP_START, 64'hFFFF_FFFF_FFFF_FFF0);
        send_cmd(OP_POLL, 64'hFFFF_FFFF_FFFF_FFFF);
        send_cmd(OP_POLL, 64'hFFFF_FFFF_FFFF_FFFF);
        send_cmd(OP_POLL, 64'd0);
        settle();
        // With no catch-up allowed a due deadline only reports a drop.
        cfg_write(REG_MAX_CATCH, 30'd0);
        send_cmd(OP_START, 64'd100);
        send_cmd(OP_POLL, 64'd15625100);
        send_cmd(OP_POLL, 64'hFFFF_FFFF_FFFF_FFFF);
        send_cmd(OP_POLL, 64'd0);

        run_phase(26, 0, 0, 30'd7, 30'd3, 30'd5, 30'd4);
        run_phase(26, 50, 0, 30'd1000000000, 30'd1, 30'd999999999, 30'd15);
        run_phase(26, 0, 50, 30'd0, 30'd1000000000, 30'd0, 30'h3FFF_FFF2);
        run_phase(26, 26, 26, 30'd1, 30'h3FFF_FFFF, 30'd1, 30'd15);
        settle();

        if (sb.error_count == 0 && sb.pending_count() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
